@@ src/bbpc_pkg.sv @@
// Package: shared types, constants and register codes of the beam-break passage counter.
package bbpc_pkg;

  // Confirmation counts for entering and leaving the blocked state
  localparam int unsigned BLOCK_CONFIRM = 2;
  localparam int unsigned CLEAR_CONFIRM = 2;
  localparam int unsigned RUN_W = 2;
  localparam logic [RUN_W-1:0] RUN_MAX = '1;

  // Register reset values
  localparam logic [15:0] BASELINE_RST  = 16'd0;
  localparam logic [12:0] TRIGGER_RST   = 13'd305;
  localparam logic [12:0] CLEAR_RST     = 13'd152;
  localparam logic        CALIB_RST     = 1'b0;
  localparam logic [31:0] OBSTRUCT_RST  = 32'd30000;

  // Configuration port geometry
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Stream widths
  localparam int unsigned IN_DATA_W  = 72;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = 88;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASELINE = 3'd0,
    REG_TRIGGER  = 3'd1,
    REG_CLEAR    = 3'd2,
    REG_CALIB    = 3'd3,
    REG_OBSTRUCT = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    OP_SAMPLE      = 2'd0,
    OP_RESET_DAILY = 2'd1,
    OP_RESET_BOTH  = 2'd2,
    OP_REARM       = 2'd3
  } opcode_e;

  typedef struct packed {
    logic [15:0] baseline_mm;
    logic [12:0] trigger_delta_mm;
    logic [12:0] clear_delta_mm;
    logic        calibrated;
    logic [31:0] obst_limit_ms;
  } cfg_t;

  typedef struct packed {
    opcode_e     opcode;
    logic        sample_valid;
    logic [15:0] distance_mm;
    logic [31:0] now_ms;
    logic        time_known;
    logic [15:0] day_number;
  } item_t;

  // Sample classification against the thresholds
  typedef struct packed {
    logic usable;      // sample is evaluated
    logic below_block; // distance below block threshold
    logic above_clear; // distance at or above clear threshold
  } class_t;

  typedef struct packed {
    logic        handled;
    logic        blocked;
    logic        obstructed;
    logic        counted;
    logic [31:0] daily_total;
    logic [31:0] lifetime_total;
    logic [15:0] event_min_mm;
  } result_t;

  // Saturating run counter step
  function automatic logic [RUN_W-1:0] run_inc(input logic [RUN_W-1:0] r);
    run_inc = (r == RUN_MAX) ? RUN_MAX : r + RUN_W'(1);
  endfunction

endpackage

@@ src/bbpc_classify.sv @@
// Threshold computation and sample classification.
module bbpc_classify (
  input  bbpc_pkg::cfg_t   cfg_i,
  input  bbpc_pkg::item_t  item_i,
  output bbpc_pkg::class_t class_o
);

  logic [15:0] trig_ext;
  logic [15:0] clr_ext;
  logic [15:0] block_thr;
  logic [15:0] clear_thr;
  logic        cfg_ok;

  // Form both thresholds from the baseline
  assign trig_ext  = {3'b000, cfg_i.trigger_delta_mm};
  assign clr_ext   = {3'b000, cfg_i.clear_delta_mm};
  assign block_thr = cfg_i.baseline_mm - trig_ext;
  assign clear_thr = cfg_i.baseline_mm - clr_ext;

  // Configuration is usable when calibrated and the baseline exceeds both deltas
  assign cfg_ok = cfg_i.calibrated && (cfg_i.baseline_mm > trig_ext) &&
                  (cfg_i.baseline_mm > clr_ext);

  assign class_o.usable      = item_i.sample_valid && cfg_ok;
  assign class_o.below_block = item_i.distance_mm < block_thr;
  assign class_o.above_clear = item_i.distance_mm >= clear_thr;

endmodule

@@ src/bbpc_core.sv @@
// Passage state, counters and per-item result computation.
module bbpc_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  bbpc_pkg::cfg_t    cfg_i,
  input  bbpc_pkg::item_t   item_i,
  input  bbpc_pkg::class_t  class_i,
  output bbpc_pkg::result_t res_o
);

  logic                       blocked_q, blocked_d;
  logic                       obstr_q, obstr_d;
  logic [bbpc_pkg::RUN_W-1:0] block_run_q, block_run_d;
  logic [bbpc_pkg::RUN_W-1:0] clear_run_q, clear_run_d;
  logic [15:0]                min_q, min_d;
  logic [31:0]                since_q, since_d;
  logic                       since_vld_q, since_vld_d;
  logic [31:0]                daily_q, daily_d;
  logic [31:0]                life_q, life_d;
  logic [15:0]                day_q, day_d;
  logic                       handled;
  logic                       counted;
  logic [bbpc_pkg::RUN_W-1:0] run_next;
  logic [31:0]                elapsed;

  assign elapsed = item_i.now_ms - since_q;

  // Compute next state for the item in the input register
  always_comb begin
    blocked_d   = blocked_q;
    obstr_d     = obstr_q;
    block_run_d = block_run_q;
    clear_run_d = clear_run_q;
    min_d       = min_q;
    since_d     = since_q;
    since_vld_d = since_vld_q;
    daily_d     = daily_q;
    life_d      = life_q;
    day_d       = day_q;
    handled     = 1'b1;
    counted     = 1'b0;
    run_next    = '0;
    case (item_i.opcode)
      bbpc_pkg::OP_RESET_DAILY: begin
        daily_d = '0;
        day_d   = item_i.time_known ? item_i.day_number : 16'd0;
      end
      bbpc_pkg::OP_RESET_BOTH: begin
        daily_d = '0;
        life_d  = '0;
      end
      bbpc_pkg::OP_REARM: begin
        blocked_d   = 1'b0;
        obstr_d     = 1'b0;
        block_run_d = '0;
        clear_run_d = '0;
        since_vld_d = 1'b0;
      end
      bbpc_pkg::OP_SAMPLE: begin
        if (!class_i.usable) begin
          handled = 1'b0;
        end else begin
          // Day rollover
          if (item_i.time_known) begin
            if (day_q == 16'd0) begin
              day_d = item_i.day_number;
            end else if (item_i.day_number != day_q) begin
              day_d   = item_i.day_number;
              daily_d = '0;
            end
          end
          if (!blocked_q) begin
            if (class_i.below_block) begin
              if (block_run_q == '0 || item_i.distance_mm < min_q) begin
                min_d = item_i.distance_mm;
              end
              run_next    = bbpc_pkg::run_inc(block_run_q);
              block_run_d = run_next;
              if (run_next >= bbpc_pkg::RUN_W'(bbpc_pkg::BLOCK_CONFIRM)) begin
                blocked_d   = 1'b1;
                since_d     = item_i.now_ms;
                since_vld_d = 1'b1;
                block_run_d = '0;
                clear_run_d = '0;
                obstr_d     = 1'b0;
                daily_d     = daily_d + 32'd1;
                life_d      = life_q + 32'd1;
                counted     = 1'b1;
              end
            end else begin
              block_run_d = '0;
            end
          end else begin
            if (item_i.distance_mm < min_q) begin
              min_d = item_i.distance_mm;
            end
            if (!obstr_q && since_vld_q && (elapsed >= cfg_i.obst_limit_ms)) begin
              obstr_d = 1'b1;
            end
            if (class_i.above_clear) begin
              run_next    = bbpc_pkg::run_inc(clear_run_q);
              clear_run_d = run_next;
              if (run_next >= bbpc_pkg::RUN_W'(bbpc_pkg::CLEAR_CONFIRM)) begin
                blocked_d   = 1'b0;
                since_d     = '0;
                since_vld_d = 1'b0;
                clear_run_d = '0;
                block_run_d = '0;
                obstr_d     = 1'b0;
              end
            end else begin
              clear_run_d = '0;
            end
          end
        end
      end
      default: begin
        handled = 1'b0;
      end
    endcase
  end

  // Result reflects the state after the item
  assign res_o.handled        = handled;
  assign res_o.blocked        = blocked_d;
  assign res_o.obstructed     = obstr_d;
  assign res_o.counted        = counted;
  assign res_o.daily_total    = daily_d;
  assign res_o.lifetime_total = life_d;
  assign res_o.event_min_mm   = min_d;

  // Commit state when the item moves to the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blocked_q   <= 1'b0;
      obstr_q     <= 1'b0;
      block_run_q <= '0;
      clear_run_q <= '0;
      min_q       <= '0;
      since_q     <= '0;
      since_vld_q <= 1'b0;
      daily_q     <= '0;
      life_q      <= '0;
      day_q       <= '0;
    end else if (fire_i) begin
      blocked_q   <= blocked_d;
      obstr_q     <= obstr_d;
      block_run_q <= block_run_d;
      clear_run_q <= clear_run_d;
      min_q       <= min_d;
      since_q     <= since_d;
      since_vld_q <= since_vld_d;
      daily_q     <= daily_d;
      life_q      <= life_d;
      day_q       <= day_d;
    end
  end

  // An obstruction only exists while blocked
  a_obstr_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    obstr_q |-> blocked_q)
    else $error("obstruction flagged while not blocked");

  // A counted passage leaves the beam blocked and bumps the lifetime count
  a_count_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && counted |=> blocked_q && (life_q == $past(life_q) + 32'd1))
    else $error("counted passage did not enter blocked state");

  // An ignored sample leaves the blocked flag, daily count, minimum and day as they were
  a_ignored_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && !handled |=> $stable(blocked_q) && $stable(daily_q) &&
                           $stable(min_q) && $stable(day_q))
    else $error("ignored sample changed state");

  // State holds while no item is committed
  a_idle_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire_i |=> $stable(life_q) && $stable(blocked_q) && $stable(block_run_q))
    else $error("state changed without a transaction");

endmodule

@@ src/beam_break_passage_counter.sv @@
// Top level: stream ports, configuration registers, input and result registers.
// Path: input register, then result register; an item waits there while the output side
// stalls. Throughput: one item per cycle while the output side does not stall; state
// update is a single pass of compare and add logic.
// Reset: asynchronous, active low; clears all passage state, both counts and the stored
// day, and loads the configuration registers with their reset values.
module beam_break_passage_counter (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration write port
  input  logic                                cfg_we_i,
  input  logic [bbpc_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [bbpc_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  // Input stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // tdata: sample_valid[0], distance_mm[16:1], now_ms[48:17], time_known[49],
  //        day_number[65:50], zero fill[71:66]
  input  logic [bbpc_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // tuser: opcode[1:0]
  input  logic [bbpc_pkg::IN_USER_W-1:0]      s_axis_tuser,
  // Result stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // tdata: handled[0], blocked[1], obstructed[2], counted[3], daily_total[35:4],
  //        lifetime_total[67:36], event_min_mm[83:68], zero fill[87:84]
  output logic [bbpc_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

  bbpc_pkg::cfg_t    cfg_q;
  bbpc_pkg::item_t   in_item_q;
  logic              in_valid_q;
  bbpc_pkg::result_t out_res_q;
  logic              out_valid_q;
  bbpc_pkg::class_t  cls;
  bbpc_pkg::result_t res;
  logic              advance;
  logic              fire;
  logic              s_accept;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.baseline_mm      <= bbpc_pkg::BASELINE_RST;
      cfg_q.trigger_delta_mm <= bbpc_pkg::TRIGGER_RST;
      cfg_q.clear_delta_mm   <= bbpc_pkg::CLEAR_RST;
      cfg_q.calibrated       <= bbpc_pkg::CALIB_RST;
      cfg_q.obst_limit_ms    <= bbpc_pkg::OBSTRUCT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bbpc_pkg::REG_BASELINE: cfg_q.baseline_mm      <= cfg_data_i[15:0];
        bbpc_pkg::REG_TRIGGER:  cfg_q.trigger_delta_mm <= cfg_data_i[12:0];
        bbpc_pkg::REG_CLEAR:    cfg_q.clear_delta_mm   <= cfg_data_i[12:0];
        bbpc_pkg::REG_CALIB:    cfg_q.calibrated       <= cfg_data_i[0];
        bbpc_pkg::REG_OBSTRUCT: cfg_q.obst_limit_ms    <= cfg_data_i[31:0];
        default: begin
        end
      endcase
    end
  end

  // Pipeline handshake
  assign advance       = !out_valid_q || m_axis_tready;
  assign fire          = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_accept) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_item_q.opcode       <= bbpc_pkg::opcode_e'(s_axis_tuser[1:0]);
      in_item_q.sample_valid <= s_axis_tdata[0];
      in_item_q.distance_mm  <= s_axis_tdata[16:1];
      in_item_q.now_ms       <= s_axis_tdata[48:17];
      in_item_q.time_known   <= s_axis_tdata[49];
      in_item_q.day_number   <= s_axis_tdata[65:50];
    end
  end

  bbpc_classify u_classify (
    .cfg_i   (cfg_q),
    .item_i  (in_item_q),
    .class_o (cls)
  );

  bbpc_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (fire),
    .cfg_i   (cfg_q),
    .item_i  (in_item_q),
    .class_i (cls),
    .res_o   (res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, out_res_q.event_min_mm, out_res_q.lifetime_total,
                          out_res_q.daily_total, out_res_q.counted, out_res_q.obstructed,
                          out_res_q.blocked, out_res_q.handled};

endmodule

@@ tb/bbpc_checker.sv @@
// Checker: follows register writes, predicts each passage counter status and compares it.
`timescale 1ns / 100ps

module bbpc_checker
  import bbpc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  // tdata: sample_valid[0], distance_mm[16:1], now_ms[48:17], time_known[49],
  //        day_number[65:50], zero fill[71:66]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // tuser: opcode[1:0]
  input  logic [IN_USER_W-1:0]  s_axis_tuser,
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // tdata: handled[0], blocked[1], obstructed[2], counted[3], daily_total[35:4],
  //        lifetime_total[67:36], event_min_mm[83:68], zero fill[87:84]
  input  logic [OUT_DATA_W-1:0] m_axis_tdata,
  output int unsigned           err_count_o,
  output int unsigned           pending_o
);

  // Register copies
  logic [15:0] base_mm;
  logic [12:0] trig_mm;
  logic [12:0] clr_mm;
  logic        calib;
  logic [31:0] obst_lim;

  // Passage state
  logic        beam_blocked;
  logic        obst_flag;
  logic [1:0]  block_streak;
  logic [1:0]  clear_streak;
  logic [15:0] event_min;
  logic [31:0] block_start;
  logic        block_start_ok;
  logic [31:0] day_total;
  logic [31:0] life_total;
  logic [15:0] cur_day;

  result_t status_q[$];
  result_t want;
  result_t got;

  // Apply one item to the state and return the status it produces
  function automatic result_t advance_counter(input opcode_e op, input logic svalid,
                                              input logic [15:0] dist_mm,
                                              input logic [31:0] now,
                                              input logic known, input logic [15:0] day);
    result_t     r;
    logic [15:0] block_thr;
    logic [15:0] clear_thr;
    r = '0;
    r.handled = 1'b1;
    block_thr = base_mm - {3'b000, trig_mm};
    clear_thr = base_mm - {3'b000, clr_mm};
    case (op)
      OP_RESET_DAILY: begin
        day_total = '0;
        cur_day   = known ? day : 16'd0;
      end
      OP_RESET_BOTH: begin
        day_total  = '0;
        life_total = '0;
      end
      OP_REARM: begin
        beam_blocked   = 1'b0;
        obst_flag      = 1'b0;
        block_streak   = '0;
        clear_streak   = '0;
        block_start_ok = 1'b0;
      end
      default: begin
        if (!svalid || !calib || base_mm <= {3'b000, trig_mm} ||
            base_mm <= {3'b000, clr_mm}) begin
          r.handled = 1'b0;
        end else begin
          // Day rollover: first known day is adopted, a later change clears today
          if (known) begin
            if (cur_day == 16'd0) begin
              cur_day = day;
            end else if (day != cur_day) begin
              cur_day   = day;
              day_total = '0;
            end
          end
          if (!beam_blocked) begin
            if (dist_mm < block_thr) begin
              if (block_streak == 2'd0 || dist_mm < event_min) event_min = dist_mm;
              if (block_streak != 2'd3) block_streak = block_streak + 2'd1;
              if (block_streak >= BLOCK_CONFIRM) begin
                beam_blocked   = 1'b1;
                block_start    = now;
                block_start_ok = 1'b1;
                block_streak   = '0;
                clear_streak   = '0;
                obst_flag      = 1'b0;
                day_total      = day_total + 32'd1;
                life_total     = life_total + 32'd1;
                r.counted      = 1'b1;
              end
            end else begin
              block_streak = '0;
            end
          end else begin
            if (dist_mm < event_min) event_min = dist_mm;
            if (!obst_flag && block_start_ok && (now - block_start) >= obst_lim)
              obst_flag = 1'b1;
            if (dist_mm >= clear_thr) begin
              if (clear_streak != 2'd3) clear_streak = clear_streak + 2'd1;
              if (clear_streak >= CLEAR_CONFIRM) begin
                beam_blocked   = 1'b0;
                block_start    = '0;
                block_start_ok = 1'b0;
                clear_streak   = '0;
                block_streak   = '0;
                obst_flag      = 1'b0;
              end
            end else begin
              clear_streak = '0;
            end
          end
        end
      end
    endcase
    r.blocked        = beam_blocked;
    r.obstructed     = obst_flag;
    r.daily_total    = day_total;
    r.lifetime_total = life_total;
    r.event_min_mm   = event_min;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, got_v);
      err_count_o++;
    end
  endtask

  // Watch both streams and the register port
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_mm        = BASELINE_RST;
      trig_mm        = TRIGGER_RST;
      clr_mm         = CLEAR_RST;
      calib          = CALIB_RST;
      obst_lim       = OBSTRUCT_RST;
      beam_blocked   = 1'b0;
      obst_flag      = 1'b0;
      block_streak   = '0;
      clear_streak   = '0;
      event_min      = '0;
      block_start    = '0;
      block_start_ok = 1'b0;
      day_total      = '0;
      life_total     = '0;
      cur_day        = '0;
      status_q.delete();
      err_count_o    = 0;
      pending_o      = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_BASELINE: base_mm  = cfg_data_i[15:0];
          REG_TRIGGER:  trig_mm  = cfg_data_i[12:0];
          REG_CLEAR:    clr_mm   = cfg_data_i[12:0];
          REG_CALIB:    calib    = cfg_data_i[0];
          REG_OBSTRUCT: obst_lim = cfg_data_i[31:0];
          default: ;
        endcase
      end
      // Compare a result transaction with the oldest prediction
      if (m_axis_tvalid && m_axis_tready) begin
        got.handled        = m_axis_tdata[0];
        got.blocked        = m_axis_tdata[1];
        got.obstructed     = m_axis_tdata[2];
        got.counted        = m_axis_tdata[3];
        got.daily_total    = m_axis_tdata[35:4];
        got.lifetime_total = m_axis_tdata[67:36];
        got.event_min_mm   = m_axis_tdata[83:68];
        if (status_q.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, actual %h", $time, m_axis_tdata);
          err_count_o++;
        end else begin
          want = status_q.pop_front();
          check_field("handled", 32'(want.handled), 32'(got.handled));
          check_field("blocked", 32'(want.blocked), 32'(got.blocked));
          check_field("obstructed", 32'(want.obstructed), 32'(got.obstructed));
          check_field("counted", 32'(want.counted), 32'(got.counted));
          check_field("daily_total", want.daily_total, got.daily_total);
          check_field("lifetime_total", want.lifetime_total, got.lifetime_total);
          check_field("event_min_mm", 32'(want.event_min_mm), 32'(got.event_min_mm));
        end
      end
      // Predict from an input transaction
      if (s_axis_tvalid && s_axis_tready) begin
        status_q.push_back(advance_counter(opcode_e'(s_axis_tuser), s_axis_tdata[0],
                                           s_axis_tdata[16:1], s_axis_tdata[48:17],
                                           s_axis_tdata[49], s_axis_tdata[65:50]));
      end
      pending_o = status_q.size();
    end
  end

endmodule

@@ tb/tb_top.sv @@
// Testbench top: clock, reset, stimulus for the passage counter and the final verdict.
`timescale 1ns / 100ps

module tb_top;
  import bbpc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned PHASE_ITEMS = 300;

  typedef enum int unsigned {DIST_BLOCK, DIST_CLEAR, DIST_BAND} dist_kind_e;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i     = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic [IN_USER_W-1:0]  s_axis_tuser  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  int unsigned err_count;
  int unsigned pending;
  int unsigned cycle_cnt    = 0;
  int unsigned item_cnt     = 0;
  int unsigned src_idle_pct = 0;
  int unsigned snk_idle_pct = 0;

  // Register values as last written, used to aim distances at the thresholds
  int unsigned sh_base;
  int unsigned sh_trig;
  int unsigned sh_clr;
  logic [31:0] sh_obst;
  logic [31:0] now_t = '0;
  logic [15:0] day_t = 16'd1;

  beam_break_passage_counter i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  bbpc_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .err_count_o   (err_count),
    .pending_o     (pending)
  );

  always #5 clk_i = ~clk_i;

  // Stall the result side at random
  always @(negedge clk_i) m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Offer one item, with a random gap first; returns at the falling edge after acceptance
  task automatic send_item(input opcode_e op, input logic svalid, input logic [15:0] dist_mm,
                           input logic [31:0] now, input logic known, input logic [15:0] day);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {6'b0, day, known, now, dist_mm, svalid};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    item_cnt++;
    @(negedge clk_i);
  endtask

  // Hold the input side until every result has come back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [31:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
  endtask

  task automatic set_config(input logic [15:0] base, input logic [12:0] trig,
                            input logic [12:0] clr, input logic cal, input logic [31:0] obst);
    sh_base = base;
    sh_trig = trig;
    sh_clr  = clr;
    sh_obst = obst;
    write_reg(REG_BASELINE, 32'(base));
    write_reg(REG_TRIGGER, 32'(trig));
    write_reg(REG_CLEAR, 32'(clr));
    write_reg(REG_CALIB, 32'(cal));
    write_reg(REG_OBSTRUCT, obst);
    cfg_we_i <= 1'b0;
  endtask

  // Distance below the block threshold, at or above the clear threshold, or in between
  function automatic logic [15:0] pick_dist(input dist_kind_e kind);
    int unsigned bthr;
    int unsigned cthr;
    if (sh_base <= sh_trig || sh_base <= sh_clr) return 16'($urandom);
    bthr = sh_base - sh_trig;
    cthr = sh_base - sh_clr;
    case (kind)
      DIST_BLOCK: return 16'($urandom_range(bthr - 1, 0));
      DIST_CLEAR: return 16'($urandom_range(65535, cthr));
      default: begin
        if (bthr < cthr) return 16'($urandom_range(cthr - 1, bthr));
        return 16'($urandom);
      end
    endcase
  endfunction

  // Advance time and maybe the day, then send one sample of the given kind
  task automatic send_sample(input dist_kind_e kind);
    logic [31:0] step;
    case ($urandom_range(19))
      0:       step = $urandom;
      1, 2:    step = sh_obst;
      default: step = $urandom_range(150);
    endcase
    now_t = now_t + step;
    if ($urandom_range(39) == 0)
      day_t = ($urandom_range(3) == 0) ? 16'($urandom) : day_t + 16'd1;
    send_item(OP_SAMPLE, ($urandom_range(29) != 0), pick_dist(kind), now_t,
              ($urandom_range(9) != 0), day_t);
  endtask

  // One object crossing the beam: approach, entry, dwell, exit
  task automatic run_passage();
    int unsigned n;
    n = $urandom_range(3);
    repeat (n) send_sample(DIST_CLEAR);
    n = $urandom_range(4, 1);
    repeat (n) send_sample(DIST_BLOCK);
    n = $urandom_range(6);
    repeat (n) send_sample(($urandom_range(3) == 0) ? DIST_BAND : DIST_BLOCK);
    n = $urandom_range(3, 1);
    repeat (n) send_sample(($urandom_range(4) == 0) ? DIST_BAND : DIST_CLEAR);
  endtask

  // Commands, invalid samples and fully random items
  task automatic send_noise();
    case ($urandom_range(3))
      0: send_item(opcode_e'($urandom_range(3, 1)), 1'($urandom), 16'($urandom), $urandom,
                   1'($urandom), 16'($urandom));
      1: send_item(OP_SAMPLE, 1'b0, 16'($urandom), $urandom, 1'($urandom), 16'($urandom));
      default: send_item(opcode_e'($urandom_range(3)), 1'($urandom), 16'($urandom),
                         $urandom, 1'($urandom), 16'($urandom));
    endcase
  endtask

  task automatic fill_to(input int unsigned target);
    while (item_cnt < target) begin
      if ($urandom_range(6) == 0) send_noise();
      else run_passage();
    end
  endtask

  initial begin
    int unsigned mid;
    int unsigned stop;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    sh_base = BASELINE_RST;
    sh_trig = TRIGGER_RST;
    sh_clr  = CLEAR_RST;
    sh_obst = OBSTRUCT_RST;

    // Directed: not calibrated after reset, so the sample is ignored
    send_item(OP_SAMPLE, 1'b1, 16'd0, 32'd0, 1'b1, 16'd0);
    drain();
    // block threshold 1695, clear threshold 1848
    set_config(16'd2000, 13'd305, 13'd152, 1'b1, 32'd100);
    send_item(OP_SAMPLE, 1'b0, 16'd0, 32'd0, 1'b1, 16'd5);
    send_item(OP_SAMPLE, 1'b1, 16'd1999, 32'd500, 1'b1, 16'd10);
    send_item(OP_SAMPLE, 1'b1, 16'd0, 32'd1000, 1'b1, 16'd10);
    send_item(OP_SAMPLE, 1'b1, 16'd1694, 32'd1010, 1'b1, 16'd10);
    send_item(OP_SAMPLE, 1'b1, 16'd1695, 32'd1050, 1'b1, 16'd10);
    // duration equals the limit exactly
    send_item(OP_SAMPLE, 1'b1, 16'd1848, 32'd1110, 1'b1, 16'd10);
    send_item(OP_SAMPLE, 1'b1, 16'hFFFF, 32'hFFFF_FFFF, 1'b0, 16'd10);
    // new day clears today's count
    send_item(OP_SAMPLE, 1'b1, 16'd5, 32'd1200, 1'b1, 16'hFFFF);
    send_item(OP_SAMPLE, 1'b1, 16'd3, 32'd1201, 1'b1, 16'hFFFF);
    send_item(OP_REARM, 1'b1, 16'd0, 32'd0, 1'b1, 16'd0);
    send_item(OP_RESET_DAILY, 1'b0, 16'd0, 32'd0, 1'b1, 16'd20);
    send_item(OP_RESET_DAILY, 1'b0, 16'd0, 32'd0, 1'b0, 16'd20);
    send_item(OP_RESET_BOTH, 1'b0, 16'd0, 32'd0, 1'b1, 16'd20);
    // blocked duration across the time wrap
    send_item(OP_SAMPLE, 1'b1, 16'd10, 32'hFFFF_FFF0, 1'b1, 16'd7);
    send_item(OP_SAMPLE, 1'b1, 16'd10, 32'hFFFF_FFF0, 1'b1, 16'd7);
    send_item(OP_SAMPLE, 1'b1, 16'd10, 32'h0000_0050, 1'b1, 16'd7);
    send_item(OP_SAMPLE, 1'b1, 16'd10, 32'h0000_0054, 1'b1, 16'd7);
    drain();
    // equal deltas and a zero obstruction limit
    set_config(16'hFFFF, 13'd5000, 13'd5000, 1'b1, 32'd0);
    send_item(OP_SAMPLE, 1'b1, 16'd60534, 32'd7, 1'b1, 16'd8);
    send_item(OP_SAMPLE, 1'b1, 16'd60534, 32'd9, 1'b1, 16'd8);
    send_item(OP_SAMPLE, 1'b1, 16'd60535, 32'd9, 1'b1, 16'd8);
    send_item(OP_SAMPLE, 1'b1, 16'd65535, 32'd9, 1'b1, 16'd8);
    drain();
    // baseline no greater than a delta: samples ignored
    set_config(16'd305, 13'd305, 13'd0, 1'b1, 32'd100);
    send_item(OP_SAMPLE, 1'b1, 16'd0, 32'd20, 1'b1, 16'd8);
    drain();
    set_config(16'd400, 13'd20, 13'd400, 1'b1, 32'd100);
    send_item(OP_SAMPLE, 1'b1, 16'd0, 32'd30, 1'b1, 16'd8);
    drain();

    // Random phases, each with its own register setting and idle pattern
    for (int ph = 0; ph < 6; ph++) begin
      src_idle_pct = (ph < 2) ? 15 : (ph < 4) ? 60 : 0;
      snk_idle_pct = (ph < 2) ? 60 : (ph < 4) ? 15 : 0;
      case (ph)
        0: set_config(16'($urandom_range(65535, 6000)), 13'($urandom_range(5000, 20)),
                      13'($urandom_range(200)), 1'b1, $urandom_range(2000, 1));
        1: set_config(16'hFFFF, 13'd5000, 13'd0, 1'b1, 32'd1);
        2: set_config(16'($urandom_range(65535, 5001)), 13'd20, 13'd5000, 1'b1,
                      32'hFFFF_FFFF);
        3: set_config(16'($urandom_range(6000, 1000)), 13'($urandom_range(900, 20)),
                      13'($urandom_range(5000)), 1'b1, $urandom_range(3000));
        4: set_config(16'($urandom_range(65535, 5001)), 13'($urandom_range(400, 20)),
                      13'($urandom_range(400)), 1'b1, 32'd0);
        default: set_config(16'($urandom_range(65535, 5001)), 13'($urandom_range(5000, 20)),
                            13'($urandom_range(5000)), 1'b1, $urandom);
      endcase
      mid  = item_cnt + PHASE_ITEMS / 2;
      stop = item_cnt + PHASE_ITEMS;
      fill_to(mid);
      drain();
      fill_to(stop);
      drain();
    end

    repeat (8) @(negedge clk_i);
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
